// File: src/zrfd_pkg.sv
// Shared types and constants for the zero-run frame decoder.
// No dependencies; imported by every module of the block.
package zrfd_pkg;

   localparam logic [7:0] END_MARK   = 8'hFF;
   localparam logic [7:0] RUN_PREFIX = 8'h00;

   // depth of the front-to-back queue, power of two
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_LITERAL,
      OP_RUN,
      OP_END
   } zrfd_op_type;

   typedef struct packed {
      zrfd_op_type op;
      logic [7:0]  value;
   } zrfd_entry_type;

   typedef struct packed {
      logic           valid;
      zrfd_entry_type entry;
   } zrfd_push_type;

   typedef struct packed {
      logic [7:0] start_index;
      logic [7:0] run_length;
      logic [7:0] cell_value;
      logic       frame_done;
      logic       last_of_item;
   } zrfd_seg_type;

endpackage

// File: src/zrfd_front.sv
// Front end: accepts received bytes, tracks the run prefix flag and
// pushes classified operations. Depends on zrfd_pkg.
module zrfd_front
   import zrfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          queue_full,
   output zrfd_push_type push
);

   logic pending_ff;
   logic pending_in;
   logic accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   always_comb begin
      pending_in       = pending_ff;
      push.valid       = 1'b0;
      push.entry.op    = OP_LITERAL;
      push.entry.value = req_tdata;
      if (accept) begin
         // end marker wins over a pending prefix and leaves the flag alone
         priority if (req_tdata == END_MARK) begin
            push.valid    = 1'b1;
            push.entry.op = OP_END;
         end else if (pending_ff) begin
            pending_in    = 1'b0;
            push.valid    = (req_tdata != RUN_PREFIX);
            push.entry.op = OP_RUN;
         end else if (req_tdata == RUN_PREFIX) begin
            pending_in = 1'b1;
         end else begin
            push.valid    = 1'b1;
            push.entry.op = OP_LITERAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

endmodule

// File: src/zrfd_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on zrfd_pkg.
module zrfd_queue
   import zrfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  zrfd_push_type push,
   output logic          full,
   output zrfd_push_type head,
   input  logic          pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   zrfd_entry_type   store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             do_pop;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = store_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push.valid) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("queue written while full");

endmodule

// File: src/zrfd_back.sv
// Back end: owns the cell position and expands operations into write segments,
// one per cycle if rsp is free, into the output register. Depends on zrfd_pkg.
module zrfd_back
   import zrfd_pkg::*;
#(
   parameter int unsigned FRAME_COLS = 16,
   parameter int unsigned FRAME_ROWS = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  zrfd_push_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output zrfd_seg_type  rsp_seg
);

   localparam int unsigned FRAME_CELLS = FRAME_COLS * FRAME_ROWS;
   localparam int unsigned CNT_W       = $clog2(FRAME_CELLS + 1);
   localparam int unsigned WIDE_W      = (CNT_W > 8) ? CNT_W : 8;

   // remainder of a run after whole frames: constant table of r mod F
   logic [7:0] mod_lut [256];
   for (genvar g = 0; g < 256; g++) begin : g_mod
      assign mod_lut[g] = 8'(g % FRAME_CELLS);
   end

   logic [CNT_W-1:0]  pos_ff;
   logic [CNT_W-1:0]  pos_in;
   logic              whole_ff;
   logic              whole_in;
   logic              rem_ff;
   logic              rem_in;
   logic [7:0]        rem_len_ff;
   logic [7:0]        rem_len_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   zrfd_seg_type      out_ff;
   zrfd_seg_type      out_in;

   logic              out_free;
   logic              busy;
   logic [CNT_W-1:0]  room;
   logic [WIDE_W-1:0] room_w;
   logic [WIDE_W-1:0] n_w;
   logic              fits;
   logic [7:0]        over;
   logic [7:0]        rem_v;
   logic              whole_v;
   logic              last_cell;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign busy       = whole_ff || rem_ff;
   assign pop        = out_free && !busy && head.valid;

   assign room       = CNT_W'(FRAME_CELLS) - pos_ff;
   assign room_w     = WIDE_W'(room);
   assign n_w        = WIDE_W'(head.entry.value);
   assign fits       = (n_w < room_w);
   assign over       = 8'(n_w - room_w);
   assign rem_v      = mod_lut[over];
   assign whole_v    = (WIDE_W'(over) >= WIDE_W'(FRAME_CELLS));
   assign last_cell  = (pos_ff == CNT_W'(FRAME_CELLS - 1));

   always_comb begin
      pos_in       = pos_ff;
      whole_in     = whole_ff;
      rem_in       = rem_ff;
      rem_len_in   = rem_len_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      if (out_free) begin
         priority if (whole_ff) begin
            out_in       = '{8'd0, 8'(FRAME_CELLS), 8'd0, 1'b1, !rem_ff};
            whole_in     = 1'b0;
            out_valid_in = 1'b1;
         end else if (rem_ff) begin
            out_in       = '{8'd0, rem_len_ff, 8'd0, 1'b0, 1'b1};
            rem_in       = 1'b0;
            out_valid_in = 1'b1;
         end else if (head.valid) begin
            out_valid_in = 1'b1;
            unique case (head.entry.op)
               OP_LITERAL: begin
                  out_in = '{8'(pos_ff), 8'd1, head.entry.value, last_cell, 1'b1};
                  pos_in = last_cell ? '0 : pos_ff + 1'b1;
               end
               OP_END: begin
                  out_in = '{8'(pos_ff), 8'd0, 8'd0, 1'b1, 1'b1};
                  pos_in = '0;
               end
               OP_RUN: begin
                  if (fits) begin
                     out_in = '{8'(pos_ff), head.entry.value, 8'd0, 1'b0, 1'b1};
                     pos_in = pos_ff + CNT_W'(head.entry.value);
                  end else begin
                     // fill to frame end; any whole frame and remainder follow
                     out_in     = '{8'(pos_ff), 8'(room), 8'd0, 1'b1,
                                    !whole_v && (rem_v == 8'd0)};
                     whole_in   = whole_v;
                     rem_in     = (rem_v != 8'd0);
                     rem_len_in = rem_v;
                     pos_in     = CNT_W'(rem_v);
                  end
               end
               default: begin
                  out_valid_in = out_valid_ff && !rsp_tready;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         whole_ff     <= 1'b0;
         rem_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         whole_ff     <= whole_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_len_ff <= rem_len_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_seg    = out_ff;

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(pos_ff) < WIDE_W'(FRAME_CELLS))
      else $error("cell position outside frame");

   a_no_pop_while_split: assert property (@(posedge clock) disable iff (reset)
      busy |-> !pop)
      else $error("new operation taken while a split run is still open");

   a_empty_seg_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.run_length == 8'd0)) |-> out_ff.frame_done)
      else $error("zero-length segment without frame end");

endmodule

// File: src/zero_run_frame_decoder.sv
// Zero-run frame decoder: one received byte per transfer, write segments out.
// Path: accepted bytes are queued, then expanded into segments in the output register.
// Throughput: one byte per cycle while the queue is not full; a run that crosses the
// frame end keeps the segment unit busy for two or three segments in all.
// Reset (synchronous): clears run/split flags, cell position, queue and output valid.
// Depends on zrfd_pkg, zrfd_front, zrfd_queue, zrfd_back.
module zero_run_frame_decoder
   import zrfd_pkg::*;
#(
   parameter int unsigned FRAME_COLS = 16,
   parameter int unsigned FRAME_ROWS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // segment stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] start_index, [15:8] run_length,
                                    // [23:16] cell_value
   output logic        rsp_tuser,   // [0] frame_done
   output logic        rsp_tlast    // last segment caused by one byte
);

   zrfd_push_type push;
   zrfd_push_type head;
   logic          queue_full;
   logic          pop;
   zrfd_seg_type  seg;

   // front: run prefix flag and classification of each transfer
   zrfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   // queue lets the front keep taking bytes while a split run drains
   zrfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // back: cell position and segment generation, registered output
   zrfd_back #(
      .FRAME_COLS (FRAME_COLS),
      .FRAME_ROWS (FRAME_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_seg    (seg)
   );

   assign rsp_tdata = {seg.cell_value, seg.run_length, seg.start_index};
   assign rsp_tuser = seg.frame_done;
   assign rsp_tlast = seg.last_of_item;

endmodule

// File: tb/zrfd_checker.sv
// Checker for the zero-run frame decoder: watches both streams, predicts the
// write segments of every accepted byte and compares them with the rsp side.
// Depends on zrfd_pkg.
`timescale 1ns / 1ps

module zrfd_checker
   import zrfd_pkg::*;
#(
   parameter int unsigned FRAME_COLS = 16,
   parameter int unsigned FRAME_ROWS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [7:0] start_index, [15:8] run_length,
                                     // [23:16] cell_value
   input  logic        rsp_tuser,    // [0] frame_done
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_count
);

   localparam int unsigned FRAME_CELLS = FRAME_COLS * FRAME_ROWS;

   // decoder state as predicted
   int unsigned    cell_pos;
   logic           run_armed;
   zrfd_seg_type   expected_segs[$];
   zrfd_seg_type   oldest;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic zrfd_seg_type make_seg(input int unsigned start, input int unsigned len,
                                             input int unsigned val, input logic done);
      zrfd_seg_type s;
      s.start_index  = start[7:0];
      s.run_length   = len[7:0];
      s.cell_value   = val[7:0];
      s.frame_done   = done;
      s.last_of_item = 1'b0;
      return s;
   endfunction

   // segments caused by one received byte, appended in order
   task automatic decode_byte(input logic [7:0] b);
      zrfd_seg_type segs [3];
      int           n;
      int unsigned  count;
      int unsigned  room;
      int unsigned  len;
      logic         done;
      n = 0;
      if (cell_pos >= FRAME_CELLS) cell_pos = 0;
      if (b == END_MARK) begin
         // marker leaves a pending run armed
         segs[n] = make_seg(cell_pos, 0, 0, 1'b1);
         n++;
         cell_pos = 0;
      end else if (run_armed) begin
         run_armed = 1'b0;
         count     = 32'(b);
         if (count > 0) begin
            room = FRAME_CELLS - cell_pos;
            len  = (count < room) ? count : room;
            done = (len == room);
            segs[n] = make_seg(cell_pos, len, 0, done);
            n++;
            cell_pos = done ? 0 : cell_pos + len;
            count -= len;
            // whole frames are reported once
            if (count >= FRAME_CELLS) begin
               segs[n] = make_seg(0, FRAME_CELLS, 0, 1'b1);
               n++;
               count = count % FRAME_CELLS;
            end
            if (count > 0) begin
               segs[n] = make_seg(0, count, 0, 1'b0);
               n++;
               cell_pos = count;
            end
         end
      end else if (b == RUN_PREFIX) begin
         run_armed = 1'b1;
      end else begin
         done = (cell_pos + 1 >= FRAME_CELLS);
         segs[n] = make_seg(cell_pos, 1, 32'(b), done);
         n++;
         cell_pos = done ? 0 : cell_pos + 1;
      end
      if (n > 0) segs[n-1].last_of_item = 1'b1;
      for (int i = 0; i < n; i++) expected_segs.push_back(segs[i]);
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cell_pos  = 0;
         run_armed = 1'b0;
         expected_segs.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_segs.size() == 0) begin
               $display("%0t: unexpected segment, expected none, actual %h user %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               oldest = expected_segs.pop_front();
               check_field("start_index", oldest.start_index, rsp_tdata[7:0]);
               check_field("run_length", oldest.run_length, rsp_tdata[15:8]);
               check_field("cell_value", oldest.cell_value, rsp_tdata[23:16]);
               check_field("frame_done", {7'd0, oldest.frame_done}, {7'd0, rsp_tuser});
               check_field("last_of_item", {7'd0, oldest.last_of_item}, {7'd0, rsp_tlast});
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
         pending_count = expected_segs.size();
      end
   end

endmodule

// File: tb/testbench.sv
// Top of the zero-run frame decoder testbench: clock, reset, byte stimulus,
// segment back-pressure and the verdict. Depends on zrfd_pkg, zrfd_checker
// and zero_run_frame_decoder.
`timescale 1ns / 1ps

module testbench
   import zrfd_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
   localparam int TAIL_CYCLES  = 16;      // settle time for the output path and segment splits
   localparam int HOLD_CYCLES  = 150;     // long rsp stall, fills the queue
   localparam int PHASE_ITEMS  = 67;      // random bytes per phase

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;        // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;                // [7:0] start, [15:8] length, [23:16] value
   logic        rsp_tuser;                // [0] frame_done
   logic        rsp_tlast;

   int          error_count;
   int          pending_count;
   int          bytes_sent  = 0;
   int          cycle_count = 0;
   int          tx_idle     = 0;          // percent of cycles the sender holds back
   int          rx_idle     = 0;          // percent of cycles the receiver stalls
   logic        hold_trigger = 1'b0;      // toggled to start one long rsp stall
   logic        hold_seen    = 1'b0;
   int          hold_left    = 0;

   // Directed bytes: both literal extremes, bare end marker, empty run,
   // fill by run then by literal, exact whole-frame run, a run giving three
   // segments, a marker while a run is armed (next byte still a count) and
   // a run crossing the frame end with a remainder.
   logic [7:0]  directed_bytes [0:20] = '{
      8'h01, 8'hFE, END_MARK,
      RUN_PREFIX, RUN_PREFIX,
      RUN_PREFIX, 8'h9E, 8'h55, 8'hAA,
      RUN_PREFIX, 8'hA0,
      RUN_PREFIX, 8'h64, RUN_PREFIX, 8'hFE,
      RUN_PREFIX, END_MARK, 8'h0A,
      RUN_PREFIX, 8'hC8, END_MARK
   };

   zero_run_frame_decoder #(
      .FRAME_COLS (16),
      .FRAME_ROWS (10)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   zrfd_checker #(
      .FRAME_COLS (16),
      .FRAME_ROWS (10)
   ) seg_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, or a long stall counted here once triggered.
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // One byte transfer. Entered and left at a falling edge; valid stays high
   // between back-to-back transfers unless an idle cycle is drawn.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Mostly well-formed traffic: literals, run pairs and frame markers,
   // with some raw bytes mixed in.
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         send_byte(8'($urandom_range(254, 1)));
      end else if (pick < 75) begin
         send_byte(RUN_PREFIX);
         send_byte(8'($urandom_range(254, 0)));
      end else if (pick < 85) begin
         send_byte(END_MARK);
      end else begin
         send_byte(8'($urandom_range(255, 0)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender idles a third of the time, receiver over half
      tx_idle = 33;
      rx_idle = 55;
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      while (bytes_sent < 21 + PHASE_ITEMS / 2) random_item();
      // long rsp stall while bytes keep coming, so req_tready drops
      hold_trigger = ~hold_trigger;
      while (bytes_sent < 21 + PHASE_ITEMS) random_item();

      // sender pauses until every segment is out
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);

      // phase two: roles swapped
      tx_idle = 55;
      rx_idle = 33;
      while (bytes_sent < 21 + 2 * PHASE_ITEMS) random_item();
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);

      // phase three: full rate both sides
      tx_idle = 0;
      rx_idle = 0;
      while (bytes_sent < 21 + 3 * PHASE_ITEMS) random_item();
      req_tvalid <= 1'b0;

      wait (pending_count == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/zrfd_pkg.sv
src/zrfd_front.sv
src/zrfd_queue.sv
src/zrfd_back.sv
src/zero_run_frame_decoder.sv
tb/zrfd_checker.sv
tb/testbench.sv
